[rtl/bdh_pkg.sv]
// package for the button debounce and key report block
// holds shared constants, register indexes, entry and control types, keycode table
// no dependencies
`default_nettype none

package bdh_pkg;

  localparam int PIN_W      = 34;
  localparam int STAMP_W    = 32;
  localparam int LIMIT_W    = 10;
  localparam int CODE_W     = 8;
  localparam int KEY_IDX_W  = 6;
  localparam int OUT_SLOTS  = 6;
  localparam int PLAYER_W   = 7;
  localparam int P1_LIMIT   = 17;
  localparam int P2_LIMIT   = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 34;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);
  localparam logic [PIN_W-1:0]   MASK_RESET  = {PIN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_LIMIT = 2'd0,
    REG_ACTIVE_LOW     = 2'd1,
    REG_BUTTON_ENABLE  = 2'd2
  } bdh_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } bdh_state_t;

  // per button stored state
  typedef struct packed {
    logic               stable;
    logic [STAMP_W-1:0] stamp;
  } bdh_entry_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic commit;
  } bdh_slot_ctrl_t;

  function automatic logic [CODE_W-1:0] keycode(input logic [KEY_IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    unique case (idx)
      6'd0:  code = 8'h52;
      6'd1:  code = 8'h51;
      6'd2:  code = 8'h50;
      6'd3:  code = 8'h4F;
      6'd4:  code = 8'h1D;
      6'd5:  code = 8'h1B;
      6'd6:  code = 8'h06;
      6'd7:  code = 8'h19;
      6'd8:  code = 8'h05;
      6'd9:  code = 8'h11;
      6'd10: code = 8'h10;
      6'd11: code = 8'h14;
      6'd12: code = 8'h1A;
      6'd13: code = 8'h08;
      6'd14: code = 8'h15;
      6'd15: code = 8'h17;
      6'd16: code = 8'h1C;
      6'd17: code = 8'h3A;
      6'd18: code = 8'h3B;
      6'd19: code = 8'h3C;
      6'd20: code = 8'h3D;
      6'd21: code = 8'h04;
      6'd22: code = 8'h16;
      6'd23: code = 8'h07;
      6'd24: code = 8'h09;
      6'd25: code = 8'h0A;
      6'd26: code = 8'h0B;
      6'd27: code = 8'h0D;
      6'd28: code = 8'h0E;
      6'd29: code = 8'h0F;
      6'd30: code = 8'h18;
      6'd31: code = 8'h0C;
      6'd32: code = 8'h12;
      6'd33: code = 8'h13;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/bdh_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module bdh_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 34,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/bdh_eval.sv]
// debounce decision for one button: timer stamp and stable level update
// depends on bdh_pkg
`default_nettype none

module bdh_eval (
  input  bdh_pkg::bdh_entry_t             entry,
  input  logic                            pressed,
  input  logic [bdh_pkg::STAMP_W-1:0]     now_ms,
  input  logic [bdh_pkg::LIMIT_W-1:0]     limit,
  output bdh_pkg::bdh_entry_t             entry_next
);

  import bdh_pkg::*;

  logic [STAMP_W-1:0] elapsed;

  assign elapsed = now_ms - entry.stamp;

  always_comb begin
    entry_next = entry;
    if (pressed != entry.stable) begin
      if (entry.stamp == '0) begin
        entry_next.stamp = now_ms;
      end else if (elapsed >= STAMP_W'(limit)) begin
        entry_next.stable = pressed;
        entry_next.stamp  = '0;
      end
    end else begin
      entry_next.stamp = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/bdh_slots.sv]
// report slot builder: inserts keycodes, skips duplicates, compares with last sent report
// depends on bdh_pkg
`default_nettype none

module bdh_slots #(
  parameter int REPORT_SLOTS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bdh_pkg::bdh_slot_ctrl_t       ctrl,
  input  logic [bdh_pkg::CODE_W-1:0]    code,
  output logic [bdh_pkg::CODE_W-1:0]    slots [REPORT_SLOTS],
  output logic                          changed
);

  import bdh_pkg::*;

  logic [CODE_W-1:0] slots_next [REPORT_SLOTS];
  logic [CODE_W-1:0] last_sent  [REPORT_SLOTS];
  logic              placed;

  // first empty or matching slot takes the code
  always_comb begin
    placed = 1'b0;
    for (int k = 0; k < REPORT_SLOTS; k++) begin
      slots_next[k] = slots[k];
    end
    for (int k = 0; k < REPORT_SLOTS; k++) begin
      if (!placed && ((slots[k] == '0) || (slots[k] == code))) begin
        placed = 1'b1;
        if (slots[k] == '0) begin
          slots_next[k] = code;
        end
      end
    end
  end

  always_comb begin
    changed = 1'b0;
    for (int k = 0; k < REPORT_SLOTS; k++) begin
      if (slots[k] != last_sent[k]) begin
        changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int k = 0; k < REPORT_SLOTS; k++) begin
        slots[k] <= '0;
      end
    end else if (ctrl.add) begin
      slots <= slots_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REPORT_SLOTS; k++) begin
        last_sent[k] <= '0;
      end
    end else if (ctrl.commit && changed) begin
      last_sent <= slots;
    end
  end

endmodule

`default_nettype wire

[rtl/button_debounce_hid_report.sv]
// Debounced button scanner forming a six-key report. Each item is one scan; the buttons are
// visited one per cycle by a single debounce unit, with their stable level and change stamp
// held in a ram (one read and one write port) backed by per-button valid bits that reset
// clears at once. An accepted item passes the scan, last and done states, then idle, where
// the block is ready again; the result sits in an output register and the next item may be
// accepted while it waits, but a following result is held until it is taken. The user must
// write configuration registers only while no item is in flight; the block does not check.
// depends on bdh_pkg, bdh_ram, bdh_eval, bdh_slots
`default_nettype none

module button_debounce_hid_report #(
  parameter int NUM_BUTTONS  = 34,
  parameter int REPORT_SLOTS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bdh_pkg::PIN_W-1:0]        pin_levels,
  input  logic [bdh_pkg::STAMP_W-1:0]      now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             report_changed,
  output logic [bdh_pkg::CODE_W-1:0]       slot_zero,
  output logic [bdh_pkg::CODE_W-1:0]       slot_one,
  output logic [bdh_pkg::CODE_W-1:0]       slot_two,
  output logic [bdh_pkg::CODE_W-1:0]       slot_three,
  output logic [bdh_pkg::CODE_W-1:0]       slot_four,
  output logic [bdh_pkg::CODE_W-1:0]       slot_five,
  output logic                             player_one_active,
  output logic                             player_two_active
);

  import bdh_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int ENTRY_W = $bits(bdh_entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  // configuration
  logic [LIMIT_W-1:0] debounce_limit;
  logic [PIN_W-1:0]   active_low_mask;
  logic [PIN_W-1:0]   button_enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit     <= LIMIT_RESET;
      active_low_mask    <= MASK_RESET;
      button_enable_mask <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_LIMIT: debounce_limit     <= cfg_data[LIMIT_W-1:0];
        REG_ACTIVE_LOW:     active_low_mask    <= cfg_data[PIN_W-1:0];
        REG_BUTTON_ENABLE:  button_enable_mask <= cfg_data[PIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  bdh_state_t     state, state_next;
  logic           accept;
  logic           issue;
  logic           load_out;
  bdh_slot_ctrl_t slot_ctrl;

  logic [IDX_W-1:0]       cnt;
  logic [PIN_W-1:0]       scan_pins;
  logic [STAMP_W-1:0]     scan_now;
  logic [NUM_BUTTONS-1:0] pins_ext;
  logic [NUM_BUTTONS-1:0] low_ext;
  logic [NUM_BUTTONS-1:0] en_ext;
  logic [NUM_BUTTONS-1:0] entry_valid;

  logic             ev_active;
  logic [IDX_W-1:0] ev_idx;
  logic             ev_pin;
  logic             ev_low;
  logic             ev_en;
  logic             ev_entry_valid;

  logic [ENTRY_W-1:0]  ram_rdata;
  bdh_entry_t          entry_cur;
  bdh_entry_t          entry_next;
  logic                pressed;
  logic                ram_we;
  logic                key_add;
  logic [PLAYER_W-1:0] ev_idx_wide;
  logic [CODE_W-1:0]   ev_code;
  logic                p1;
  logic                p2;

  logic [CODE_W-1:0] slots   [REPORT_SLOTS];
  logic [CODE_W-1:0] out_slot [OUT_SLOTS];
  logic              slot_changed;

  // buttons beyond the pin field read as released and disabled
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_ext
    if (i < PIN_W) begin : g_pin
      assign pins_ext[i] = scan_pins[i];
      assign low_ext[i]  = active_low_mask[i];
      assign en_ext[i]   = button_enable_mask[i];
    end else begin : g_none
      assign pins_ext[i] = 1'b0;
      assign low_ext[i]  = 1'b0;
      assign en_ext[i]   = 1'b0;
    end
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    issue    = (state == ST_SCAN);
    load_out = (state == ST_DONE) && (!out_valid || out_ready);
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (cnt == LAST_IDX) state_next = ST_LAST;
      ST_LAST: state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (issue && (cnt != LAST_IDX)) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_pins <= pin_levels;
      scan_now  <= now_ms;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_active <= 1'b0;
    end else begin
      ev_active <= issue;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx         <= cnt;
    ev_pin         <= pins_ext[cnt];
    ev_low         <= low_ext[cnt];
    ev_en          <= en_ext[cnt];
    ev_entry_valid <= entry_valid[cnt];
  end

  bdh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ev_idx),
    .wdata (ENTRY_W'(entry_next)),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // evaluate stage
  assign entry_cur = ev_entry_valid ? bdh_entry_t'(ram_rdata) : '0;
  assign pressed   = ev_low ? ~ev_pin : ev_pin;

  bdh_eval u_eval (
    .entry      (entry_cur),
    .pressed    (pressed),
    .now_ms     (scan_now),
    .limit      (debounce_limit),
    .entry_next (entry_next)
  );

  assign ram_we      = ev_active && ev_en;
  assign key_add     = ram_we && entry_next.stable;
  assign ev_idx_wide = PLAYER_W'(ev_idx);
  assign ev_code     = keycode(KEY_IDX_W'(ev_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[ev_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else if (key_add) begin
      priority if (ev_idx_wide < PLAYER_W'(P1_LIMIT)) begin
        p1 <= 1'b1;
      end else if (ev_idx_wide < PLAYER_W'(P2_LIMIT)) begin
        p2 <= 1'b1;
      end
    end
  end

  assign slot_ctrl = '{clear: accept, add: key_add, commit: load_out};

  bdh_slots #(
    .REPORT_SLOTS (REPORT_SLOTS)
  ) u_slots (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (slot_ctrl),
    .code    (ev_code),
    .slots   (slots),
    .changed (slot_changed)
  );

  for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_out
    if (k < REPORT_SLOTS) begin : g_used
      assign out_slot[k] = slots[k];
    end else begin : g_empty
      assign out_slot[k] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      report_changed    <= slot_changed;
      slot_zero         <= out_slot[0];
      slot_one          <= out_slot[1];
      slot_two          <= out_slot[2];
      slot_three        <= out_slot[3];
      slot_four         <= out_slot[4];
      slot_five         <= out_slot[5];
      player_one_active <= p1;
      player_two_active <= p2;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && issue) |-> (cnt != ev_idx))
    else $error("state ram written at the address being read");

  a_load_after_eval: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !ev_active)
    else $error("result loaded while a button is still being evaluated");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second item taken before the scan started");

  a_eval_window: assert property (@(posedge clk) disable iff (rst)
    ev_active |-> ((state == ST_SCAN) || (state == ST_LAST)))
    else $error("button evaluated outside the scan");
`endif

endmodule

`default_nettype wire

[tb/button_debounce_hid_report_tb.sv]
// testbench for button_debounce_hid_report: directed and random scans through a debounce
// predictor kept in a small scoreboard class, with random gaps and stalls on both channels
// depends on bdh_pkg and the button_debounce_hid_report rtl
`default_nettype none

module button_debounce_hid_report_tb;
  import bdh_pkg::*;

  localparam logic [PIN_W-1:0] ALL_HIGH = {PIN_W{1'b1}};

  localparam logic [0:PIN_W-1][CODE_W-1:0] KEY_CODES = {
    8'h52, 8'h51, 8'h50, 8'h4F, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h14,
    8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
    8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E,
    8'h0F, 8'h18, 8'h0C, 8'h12, 8'h13
  };

  typedef struct packed {
    logic                             changed;
    logic [OUT_SLOTS-1:0][CODE_W-1:0] slot;
    logic                             player_one;
    logic                             player_two;
  } key_report_t;

  class report_scoreboard;
    logic [LIMIT_W-1:0] limit_ms;
    logic [PIN_W-1:0]   act_low;
    logic [PIN_W-1:0]   enabled;
    logic               stable_q [PIN_W];
    logic [STAMP_W-1:0] stamp_q [PIN_W];
    logic [CODE_W-1:0]  sent_q [OUT_SLOTS];
    key_report_t        expected_reports [$];
    int                 errors;

    function new();
      limit_ms = LIMIT_RESET;
      act_low  = MASK_RESET;
      enabled  = MASK_RESET;
      errors   = 0;
      for (int i = 0; i < PIN_W; i++) begin
        stable_q[i] = 1'b0;
        stamp_q[i]  = '0;
      end
      for (int k = 0; k < OUT_SLOTS; k++) sent_q[k] = '0;
    endfunction

    function void set_reg(bdh_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE_LIMIT: limit_ms = data[LIMIT_W-1:0];
        REG_ACTIVE_LOW:     act_low  = data[PIN_W-1:0];
        REG_BUTTON_ENABLE:  enabled  = data[PIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_scan(logic [PIN_W-1:0] pins, logic [STAMP_W-1:0] now);
      key_report_t        r;
      logic               pressed;
      logic               placed;
      logic [STAMP_W-1:0] elapsed;
      r = '0;
      for (int i = 0; i < PIN_W; i++) begin
        if (enabled[i]) begin
          pressed = act_low[i] ? !pins[i] : pins[i];
          if (pressed != stable_q[i]) begin
            elapsed = now - stamp_q[i];
            if (stamp_q[i] == '0) begin
              stamp_q[i] = now;
            end else if (elapsed >= STAMP_W'(limit_ms)) begin
              stable_q[i] = pressed;
              stamp_q[i]  = '0;
            end
          end else begin
            stamp_q[i] = '0;
          end
          if (stable_q[i]) begin
            placed = 1'b0;
            for (int k = 0; k < OUT_SLOTS; k++) begin
              if (!placed) begin
                if (r.slot[k] == '0) begin
                  r.slot[k] = KEY_CODES[i];
                  placed = 1'b1;
                end else if (r.slot[k] == KEY_CODES[i]) begin
                  placed = 1'b1;
                end
              end
            end
            if (i < P1_LIMIT) r.player_one = 1'b1;
            else r.player_two = 1'b1;
          end
        end
      end
      for (int k = 0; k < OUT_SLOTS; k++)
        if (r.slot[k] != sent_q[k]) r.changed = 1'b1;
      if (r.changed)
        for (int k = 0; k < OUT_SLOTS; k++) sent_q[k] = r.slot[k];
      expected_reports.push_back(r);
    endfunction

    function void check_report(key_report_t a);
      key_report_t e;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, actual %h", $time, a);
        errors++;
        return;
      end
      e = expected_reports.pop_front();
      if (a.changed !== e.changed) begin
        $display("%0t: report_changed expected %0b actual %0b", $time, e.changed, a.changed);
        errors++;
      end
      for (int k = 0; k < OUT_SLOTS; k++)
        if (a.slot[k] !== e.slot[k]) begin
          $display("%0t: slot %0d expected %02h actual %02h", $time, k, e.slot[k], a.slot[k]);
          errors++;
        end
      if (a.player_one !== e.player_one) begin
        $display("%0t: player_one_active expected %0b actual %0b", $time,
                 e.player_one, a.player_one);
        errors++;
      end
      if (a.player_two !== e.player_two) begin
        $display("%0t: player_two_active expected %0b actual %0b", $time,
                 e.player_two, a.player_two);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIN_W-1:0]      pin_levels = '0;
  logic [STAMP_W-1:0]    now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  report_changed;
  logic [CODE_W-1:0]     slot_zero, slot_one, slot_two, slot_three, slot_four, slot_five;
  logic                  player_one_active, player_two_active;

  report_scoreboard sb = new();
  bit                 tx_burst = 1'b0;
  bit                 rx_burst = 1'b0;
  logic [STAMP_W-1:0] tick;
  logic [PIN_W-1:0]   held_pins;

  button_debounce_hid_report dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pin_levels(pin_levels), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .report_changed(report_changed),
    .slot_zero(slot_zero), .slot_one(slot_one), .slot_two(slot_two),
    .slot_three(slot_three), .slot_four(slot_four), .slot_five(slot_five),
    .player_one_active(player_one_active), .player_two_active(player_two_active)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [PIN_W-1:0] rand_pins();
    return {2'($urandom_range(0, 3)), 32'($urandom())};
  endfunction

  task automatic drive_scan(input logic [PIN_W-1:0] pins, input logic [STAMP_W-1:0] now);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid   = 1'b1;
    pin_levels = pins;
    now_ms     = now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_scan(pins, now);
  endtask

  // lower valid and let every outstanding report drain
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input bdh_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  // receiver side, with one long hold-off so the block backs up
  initial begin
    int  gap;
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    forever begin
      if (taken == 300 && !held) begin
        held = 1'b1;
        repeat (400) begin
          @(negedge clk);
          out_ready = 1'b0;
        end
      end
      gap = rx_burst ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) rx_burst = !rx_burst;
      repeat (gap) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    key_report_t a;
    if (!rst && out_valid && out_ready) begin
      a.changed    = report_changed;
      a.slot[0]    = slot_zero;
      a.slot[1]    = slot_one;
      a.slot[2]    = slot_two;
      a.slot[3]    = slot_three;
      a.slot[4]    = slot_four;
      a.slot[5]    = slot_five;
      a.player_one = player_one_active;
      a.player_two = player_two_active;
      sb.check_report(a);
    end
  end

  initial begin
    #5000000;
    $display("button_debounce_hid_report_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // reset settings: limit five, all active low, all enabled
    drive_scan(ALL_HIGH, 32'd1);
    drive_scan('0, 32'd0);
    drive_scan('0, 32'd1);
    drive_scan('0, 32'd5);
    drive_scan('0, 32'd6);
    drive_scan('0, 32'd7);
    drive_scan(34'h3F, 32'd8);
    drive_scan(34'h3F, 32'd13);
    drive_scan(ALL_HIGH, 32'd14);
    drive_scan(34'h3F, 32'd20);
    drive_scan(ALL_HIGH, 32'd21);
    drive_scan(ALL_HIGH, 32'd26);
    drive_scan('0, 32'hFFFF_FFFE);
    drive_scan('0, 32'd3);
    drive_scan(ALL_HIGH, 32'hFFFF_FFFF);
    drive_scan(ALL_HIGH, 32'h8000_0000);
    settle();

    write_reg(REG_DEBOUNCE_LIMIT, '0);
    drive_scan(34'h1_FFFF_FFFF, 32'd100);
    drive_scan(34'h1_FFFF_FFFF, 32'd100);
    settle();
    write_reg(REG_BUTTON_ENABLE, '0);
    drive_scan('0, 32'd101);
    settle();
    write_reg(REG_BUTTON_ENABLE, ALL_HIGH);
    write_reg(REG_ACTIVE_LOW, '0);
    drive_scan(34'h2_0000_0000, 32'd102);
    settle();
    write_reg(REG_DEBOUNCE_LIMIT, 34'd1000);
    drive_scan(ALL_HIGH, 32'd200);
    drive_scan(ALL_HIGH, 32'd1199);
    drive_scan(ALL_HIGH, 32'd1200);
    settle();

    tick      = 32'd5000;
    held_pins = rand_pins();
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_DEBOUNCE_LIMIT, '0);
        1: write_reg(REG_DEBOUNCE_LIMIT, 34'd1);
        2: write_reg(REG_DEBOUNCE_LIMIT, 34'd5);
        3: write_reg(REG_DEBOUNCE_LIMIT, 34'd1000);
        4: write_reg(REG_DEBOUNCE_LIMIT, CFG_DATA_W'($urandom_range(0, 1000)));
        default: write_reg(REG_DEBOUNCE_LIMIT, CFG_DATA_W'($urandom_range(0, 12)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_ACTIVE_LOW, '0);
        1: write_reg(REG_ACTIVE_LOW, ALL_HIGH);
        default: write_reg(REG_ACTIVE_LOW, rand_pins());
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(REG_BUTTON_ENABLE, '0);
        1, 2: write_reg(REG_BUTTON_ENABLE, ALL_HIGH);
        default: write_reg(REG_BUTTON_ENABLE, rand_pins());
      endcase

      for (int n = 0; n < 150; n++) begin
        logic [PIN_W-1:0] pins;
        if ($urandom_range(0, 7) == 0) held_pins = held_pins ^ (rand_pins() & rand_pins());
        pins = held_pins;
        if ($urandom_range(0, 3) == 0) pins = pins ^ (rand_pins() & rand_pins() & rand_pins());
        if ($urandom_range(0, 15) == 0) pins = rand_pins();
        case ($urandom_range(0, 15))
          0: tick = $urandom();
          1: tick = '0;
          2: tick = tick + 32'd1000 + 32'($urandom_range(0, 3));
          3: tick = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
          default: tick = tick + 32'($urandom_range(0, 3));
        endcase
        drive_scan(pins, tick);
      end
      settle();
    end

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("button_debounce_hid_report_tb OK");
    else
      $display("button_debounce_hid_report_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/bdh_pkg.sv
rtl/bdh_ram.sv
rtl/bdh_eval.sv
rtl/bdh_slots.sv
rtl/button_debounce_hid_report.sv
tb/button_debounce_hid_report_tb.sv
